[design/lfu_pkg.sv]
package lfu_pkg;

   // Cache geometry and field widths.
   localparam int MAX_ENTRIES = 16;
   localparam int TAG_BITS    = 32;
   localparam int ADDR_BITS   = 32;
   localparam int COUNT_BITS  = 32;
   localparam int STAMP_BITS  = 64;
   localparam int CAP_BITS    = 5;
   localparam int IDX_BITS    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_BITS    = $clog2(MAX_ENTRIES + 1);

   localparam logic [CAP_BITS-1:0]   CAP_RESET = CAP_BITS'(16);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // One stored cache entry, as it sits in the entry memory.
   typedef struct packed {
      logic [TAG_BITS-1:0]   tag;
      logic [COUNT_BITS-1:0] count;
      logic [STAMP_BITS-1:0] stamp;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // Lookup sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

[design/lfu_cache_lookup.sv]
// A request transfer starts a scan that reads one entry per cycle from the entry
// memory; a hit ends the scan early, else it runs over all entries. The response
// is posted from the done state once the response register is free; no new request
// is taken until then, since req_stall is high whenever the sequencer is not idle.
// Reset (synchronous): all entries invalid, occupancy and stamp zero,
// capacity 16; the entry memory itself is not cleared.
module lfu_cache_lookup
   import lfu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ADDR_BITS-1:0]  req_address_tag,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_hit,
   output logic                  rsp_evicted_valid,
   output logic [ADDR_BITS-1:0]  rsp_evicted_tag,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CAP_BITS-1:0]   csr_data
);

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(MAX_ENTRIES - 1);

   state_type state_ff, state_in;

   logic [CAP_BITS-1:0]    cap_ff;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [OCC_BITS-1:0]    occ_ff, occ_in;
   logic [STAMP_BITS-1:0]  stamp_ff, stamp_in;

   logic [TAG_BITS-1:0]    tag_ff, tag_in;
   logic [IDX_BITS-1:0]    scan_idx_ff, scan_idx_in;
   logic                   hit_ff, hit_in;
   logic [IDX_BITS-1:0]    hit_idx_ff, hit_idx_in;
   logic [COUNT_BITS-1:0]  hit_count_ff, hit_count_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_BITS-1:0]    free_idx_ff, free_idx_in;
   logic                   victim_found_ff, victim_found_in;
   logic [IDX_BITS-1:0]    victim_idx_ff, victim_idx_in;
   logic [COUNT_BITS+STAMP_BITS-1:0] victim_key_ff, victim_key_in;
   logic [TAG_BITS-1:0]    victim_tag_ff, victim_tag_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic                   rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [ADDR_BITS-1:0]   rsp_ev_tag_ff, rsp_ev_tag_in;

   logic                   ram_wr_en;
   logic [IDX_BITS-1:0]    ram_wr_addr;
   entry_type              ram_wr_entry;
   logic [IDX_BITS-1:0]    ram_rd_addr;
   logic [ENTRY_BITS-1:0]  ram_rd_data;
   entry_type              rd_entry;

   logic                   req_xfer;
   logic                   cur_valid;
   logic                   cur_match;
   logic [COUNT_BITS+STAMP_BITS-1:0] cur_key;
   logic [OCC_BITS-1:0]    eff_cap;
   logic                   out_free;
   logic                   use_free;
   logic                   do_evict;
   logic [63:0]            tag_wide;
   logic [63:0]            ev_tag_wide;

   // Entry memory: tag, use count and age stamp of every entry.
   lfu_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(MAX_ENTRIES)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_entry),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Handshake outputs.
   assign req_stall         = (state_ff != ST_IDLE);
   assign req_xfer          = req_valid && !req_stall;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_tag   = rsp_ev_tag_ff;

   // Entry under inspection during the scan.
   assign rd_entry  = entry_type'(ram_rd_data);
   assign cur_valid = valid_ff[scan_idx_ff];
   assign cur_match = cur_valid && (rd_entry.tag == tag_ff);
   assign cur_key   = {rd_entry.count, rd_entry.stamp};
   assign tag_wide  = 64'(req_address_tag);
   assign ev_tag_wide = 64'(victim_tag_ff);

   // Capacity clamped to the range one to MAX_ENTRIES.
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = OCC_BITS'(1);
      end else if (32'(cap_ff) > 32'(MAX_ENTRIES)) begin
         eff_cap = OCC_BITS'(MAX_ENTRIES);
      end else begin
         eff_cap = OCC_BITS'(cap_ff);
      end
   end

   // Response register is free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign use_free = !hit_ff && free_found_ff && (occ_ff < eff_cap);
   assign do_evict = !hit_ff && !use_free && victim_found_ff;

   // Sequencer: next state, scan bookkeeping and write-back.
   always_comb begin
      state_in        = state_ff;
      valid_in        = valid_ff;
      occ_in          = occ_ff;
      stamp_in        = stamp_ff;
      tag_in          = tag_ff;
      scan_idx_in     = scan_idx_ff;
      hit_in          = hit_ff;
      hit_idx_in      = hit_idx_ff;
      hit_count_in    = hit_count_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      victim_found_in = victim_found_ff;
      victim_idx_in   = victim_idx_ff;
      victim_key_in   = victim_key_ff;
      victim_tag_in   = victim_tag_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_hit_in      = rsp_hit_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_tag_in   = rsp_ev_tag_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = victim_idx_ff;
      ram_wr_entry    = '{tag: tag_ff, count: COUNT_BITS'(1), stamp: stamp_ff};
      ram_rd_addr     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               tag_in          = tag_wide[TAG_BITS-1:0];
               scan_idx_in     = '0;
               hit_in          = 1'b0;
               free_found_in   = 1'b0;
               victim_found_in = 1'b0;
               state_in        = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Fetch the next entry while judging the current one.
            ram_rd_addr = IDX_BITS'(scan_idx_ff + 1'b1);
            scan_idx_in = IDX_BITS'(scan_idx_ff + 1'b1);
            if (cur_match) begin
               hit_in       = 1'b1;
               hit_idx_in   = scan_idx_ff;
               hit_count_in = rd_entry.count;
               state_in     = ST_DONE;
            end else begin
               if (!cur_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = scan_idx_ff;
               end
               // Smallest count wins; among equal counts the oldest stamp.
               if (cur_valid && (!victim_found_ff || cur_key < victim_key_ff)) begin
                  victim_found_in = 1'b1;
                  victim_idx_in   = scan_idx_ff;
                  victim_key_in   = cur_key;
                  victim_tag_in   = rd_entry.tag;
               end
               if (scan_idx_ff == LAST_IDX) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (out_free) begin
               // Write back the touched entry and post the response.
               ram_wr_en = hit_ff || use_free || do_evict;
               if (hit_ff) begin
                  ram_wr_addr        = hit_idx_ff;
                  ram_wr_entry.count = (hit_count_ff != COUNT_MAX) ?
                                       COUNT_BITS'(hit_count_ff + 1'b1) : hit_count_ff;
               end else if (use_free) begin
                  ram_wr_addr = free_idx_ff;
                  occ_in      = OCC_BITS'(occ_ff + 1'b1);
               end
               if (ram_wr_en) begin
                  stamp_in = STAMP_BITS'(stamp_ff + 1'b1);
                  valid_in[ram_wr_addr] = 1'b1;
               end
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = hit_ff;
               rsp_ev_valid_in = do_evict;
               rsp_ev_tag_in   = do_evict ? ev_tag_wide[ADDR_BITS-1:0] : '0;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers and the capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         valid_ff     <= '0;
         occ_ff       <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan and response payload registers.
   always_ff @(posedge clock) begin
      tag_ff          <= tag_in;
      scan_idx_ff     <= scan_idx_in;
      hit_ff          <= hit_in;
      hit_idx_ff      <= hit_idx_in;
      hit_count_ff    <= hit_count_in;
      free_found_ff   <= free_found_in;
      free_idx_ff     <= free_idx_in;
      victim_found_ff <= victim_found_in;
      victim_idx_ff   <= victim_idx_in;
      victim_key_ff   <= victim_key_in;
      victim_tag_ff   <= victim_tag_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_tag_ff   <= rsp_ev_tag_in;
   end

endmodule

[design/lfu_ram.sv]
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[tb/tb_lfu_cache_lookup.sv]
module tb_lfu_cache_lookup
   import lfu_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // One response as the block reports it.
   typedef struct packed {
      logic                 hit;
      logic                 evicted_valid;
      logic [ADDR_BITS-1:0] evicted_tag;
   } lookup_result_type;

   // A directed step either writes the capacity or looks up one tag.
   typedef enum logic {
      ROW_LOOKUP,
      ROW_CAPACITY
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [ADDR_BITS-1:0] value;
      logic                 fixed_want;
      lookup_result_type    want;
   } plan_row_type;

   localparam lookup_result_type MISS_FREE = '{1'b0, 1'b0, '0};
   localparam lookup_result_type HIT_ONLY  = '{1'b1, 1'b0, '0};

   // Directed steps. The first lookups after reset have obvious answers typed in;
   // the rest go through the predictor. They cover tag extremes, a capacity of
   // zero, a capacity above the entry count, and capacity lowered below occupancy.
   localparam plan_row_type DIRECTED [0:22] = '{
      '{ROW_LOOKUP,   32'h0000_0000, 1'b1, MISS_FREE},
      '{ROW_LOOKUP,   32'hFFFF_FFFF, 1'b1, MISS_FREE},
      '{ROW_LOOKUP,   32'h0000_0000, 1'b1, HIT_ONLY},
      '{ROW_LOOKUP,   32'hFFFF_FFFF, 1'b1, HIT_ONLY},
      '{ROW_LOOKUP,   32'h0000_0000, 1'b0, MISS_FREE},
      '{ROW_CAPACITY, 32'd2,         1'b0, MISS_FREE},
      '{ROW_LOOKUP,   32'h1234_5678, 1'b0, MISS_FREE},
      '{ROW_LOOKUP,   32'h8765_4321, 1'b0, MISS_FREE},
      '{ROW_CAPACITY, 32'd0,         1'b0, MISS_FREE},
      '{ROW_LOOKUP,   32'h1111_1111, 1'b0, MISS_FREE},
      '{ROW_LOOKUP,   32'h2222_2222, 1'b0, MISS_FREE},
      '{ROW_LOOKUP,   32'h2222_2222, 1'b0, MISS_FREE},
      '{ROW_CAPACITY, 32'd31,        1'b0, MISS_FREE},
      '{ROW_LOOKUP,   32'h3333_3333, 1'b0, MISS_FREE},
      '{ROW_LOOKUP,   32'h4444_4444, 1'b0, MISS_FREE},
      '{ROW_LOOKUP,   32'h3333_3333, 1'b0, MISS_FREE},
      '{ROW_CAPACITY, 32'd1,         1'b0, MISS_FREE},
      '{ROW_LOOKUP,   32'h5555_5555, 1'b0, MISS_FREE},
      '{ROW_LOOKUP,   32'h6666_6666, 1'b0, MISS_FREE},
      '{ROW_LOOKUP,   32'h4444_4444, 1'b0, MISS_FREE},
      '{ROW_CAPACITY, 32'd16,        1'b0, MISS_FREE},
      '{ROW_LOOKUP,   32'h8000_0000, 1'b0, MISS_FREE},
      '{ROW_LOOKUP,   32'h0000_0001, 1'b0, MISS_FREE}
   };

   // Capacity for each random phase; one phase draws its own value instead.
   localparam logic [CAP_BITS-1:0] PHASE_CAPACITY [0:9] = '{
      5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd8, 5'd17, 5'd2, 5'd5, 5'd16
   };
   localparam int DRAWN_PHASE     = 8;
   localparam int QUIET_PHASES    = 2;
   localparam int ITEMS_PER_PHASE = 80;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   logic [ADDR_BITS-1:0] req_address_tag   = '0;
   logic                 rsp_valid;
   logic                 rsp_stall         = 1'b0;
   logic                 rsp_hit;
   logic                 rsp_evicted_valid;
   logic [ADDR_BITS-1:0] rsp_evicted_tag;
   logic                 csr_valid         = 1'b0;
   logic                 csr_ready;
   logic [CAP_BITS-1:0]  csr_data          = '0;

   // Shadow copy of the cache contents and the capacity register.
   logic                  shadow_valid [MAX_ENTRIES];
   entry_type             shadow_entry [MAX_ENTRIES];
   int unsigned           shadow_occupancy;
   logic [STAMP_BITS-1:0] shadow_stamp_next;
   logic [CAP_BITS-1:0]   shadow_capacity;

   lookup_result_type pending_results [$];
   int                error_count = 0;
   bit                quiet       = 1'b0;
   int                stall_left  = 0;

   always #5 clock = ~clock;

   lfu_cache_lookup dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_address_tag   (req_address_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_tag   (rsp_evicted_tag),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   // Looks up one tag in the shadow cache, updates it, and returns the response.
   function automatic lookup_result_type predict_lookup(input logic [ADDR_BITS-1:0] address);
      logic [TAG_BITS-1:0] tag;
      int                  victim;
      int unsigned         limit;
      lookup_result_type   result;
      tag    = address[TAG_BITS-1:0];
      victim = -1;
      result = '0;
      limit  = (shadow_capacity == 0) ? 1 :
               (shadow_capacity > MAX_ENTRIES) ? MAX_ENTRIES : shadow_capacity;

      // A hit bumps the count unless it is saturated, and always restamps.
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (shadow_valid[i] && shadow_entry[i].tag == tag) begin
            if (shadow_entry[i].count != COUNT_MAX)
               shadow_entry[i].count = shadow_entry[i].count + 1'b1;
            shadow_entry[i].stamp = shadow_stamp_next;
            shadow_stamp_next     = shadow_stamp_next + 1'b1;
            result.hit            = 1'b1;
            return result;
         end
      end

      // Below capacity, the lowest free entry takes the tag.
      if (shadow_occupancy < limit) begin
         for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!shadow_valid[i])
               victim = i;
         end
         if (victim >= 0)
            shadow_occupancy++;
      end

      // Otherwise evict the smallest count, oldest stamp among ties.
      if (victim < 0) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (shadow_valid[i] &&
                (victim < 0 ||
                 shadow_entry[i].count < shadow_entry[victim].count ||
                 (shadow_entry[i].count == shadow_entry[victim].count &&
                  shadow_entry[i].stamp < shadow_entry[victim].stamp)))
               victim = i;
         end
         if (victim >= 0) begin
            result.evicted_valid = 1'b1;
            result.evicted_tag   = ADDR_BITS'(shadow_entry[victim].tag);
         end
      end

      if (victim >= 0) begin
         shadow_valid[victim]       = 1'b1;
         shadow_entry[victim].tag   = tag;
         shadow_entry[victim].count = COUNT_BITS'(1);
         shadow_entry[victim].stamp = shadow_stamp_next;
         shadow_stamp_next          = shadow_stamp_next + 1'b1;
      end
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // Sends one lookup, sometimes after a gap, and queues its expected response.
   task automatic send_lookup(input logic [ADDR_BITS-1:0] address, input logic use_fixed,
                              input lookup_result_type fixed);
      lookup_result_type predicted;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_address_tag <= address;
      do @(posedge clock); while (req_stall);
      predicted = predict_lookup(address);
      pending_results.push_back(use_fixed ? fixed : predicted);
   endtask

   // Writes the capacity once every pending response has come back.
   task automatic write_capacity(input logic [CAP_BITS-1:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid       <= 1'b0;
      shadow_capacity  = value;
   endtask

   // Response stall comes in bursts of random length.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left  = 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left  = $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Each response transfer is checked against the oldest expected response.
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with no lookup pending");
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch($sformatf("hit %b, want %b", rsp_hit, want.hit));
            if (rsp_evicted_valid !== want.evicted_valid)
               report_mismatch($sformatf("evicted_valid %b, want %b",
                                         rsp_evicted_valid, want.evicted_valid));
            if (rsp_evicted_tag !== want.evicted_tag)
               report_mismatch($sformatf("evicted_tag %h, want %h",
                                         rsp_evicted_tag, want.evicted_tag));
         end
      end
   end

   // Main sequence: reset, directed steps, then random phases.
   initial begin
      logic [ADDR_BITS-1:0] tag_pool [$];
      logic [ADDR_BITS-1:0] address;
      logic [CAP_BITS-1:0]  capacity;
      int                   pick;
      for (int i = 0; i < MAX_ENTRIES; i++)
         shadow_valid[i] = 1'b0;
      shadow_occupancy  = 0;
      shadow_stamp_next = '0;
      shadow_capacity   = CAP_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_CAPACITY)
            write_capacity(DIRECTED[i].value[CAP_BITS-1:0]);
         else
            send_lookup(DIRECTED[i].value, DIRECTED[i].fixed_want, DIRECTED[i].want);
      end

      // Each phase reuses a small pool of tags, skewed toward the first few so
      // that use counts spread apart, with some fresh random tags mixed in.
      for (int phase = 0; phase < $size(PHASE_CAPACITY); phase++) begin
         quiet    = (phase >= $size(PHASE_CAPACITY) - QUIET_PHASES);
         capacity = (phase == DRAWN_PHASE) ? CAP_BITS'($urandom_range(0, 31))
                                           : PHASE_CAPACITY[phase];
         write_capacity(capacity);
         tag_pool.delete();
         repeat ($urandom_range(2, 24)) tag_pool.push_back($urandom());
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) < 8) begin
               pick    = $urandom_range(0, $urandom_range(0, tag_pool.size() - 1));
               address = tag_pool[pick];
            end else begin
               address = $urandom();
            end
            send_lookup(address, 1'b0, MISS_FREE);
         end
      end

      // Drain the remaining responses and watch for strays.
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("tb_lfu_cache_lookup: done, clean");
      else
         $display("tb_lfu_cache_lookup: done, errors");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("tb_lfu_cache_lookup: done, errors");
      $finish;
   end

endmodule
